### rtl/core/hfd_pkg.sv
// Package for the halfband decimate-by-two FIR: sizes, request codes,
// sequencer states and the MAC control word.
// No dependencies.
package hfd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 18;
    localparam int MAX_TAPS    = 64;

    localparam int ADDR_W  = $clog2(MAX_TAPS);
    localparam int LEN_W   = 6;
    localparam int LW      = ((LEN_W > ADDR_W) ? LEN_W : ADDR_W) + 1;
    localparam int CNT_W   = ADDR_W + 1;
    localparam int HIST_W  = 2 * SAMPLE_BITS;
    localparam int PROD_W  = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W   = PROD_W + ADDR_W;

    localparam int LEN_MIN = 3;
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(11);

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic hvalid;
    } mac_ctrl_t;

endpackage

### rtl/core/hfd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module hfd_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/hfd_mac.sv
// Complex multiply-accumulate datapath with round-half-up and saturation.
// Depends on hfd_pkg.
module hfd_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  hfd_pkg::mac_ctrl_t                  ctrl,
    input  logic [hfd_pkg::COEF_BITS-1:0]       coef,
    input  logic [hfd_pkg::HIST_W-1:0]          hist,
    output logic                                done,
    output logic [hfd_pkg::SAMPLE_BITS-1:0]     res_i,
    output logic [hfd_pkg::SAMPLE_BITS-1:0]     res_q
);

    localparam int AW = hfd_pkg::ACC_W + 1;
    localparam logic signed [AW-1:0] RND    = AW'(2 ** (hfd_pkg::COEF_BITS - 2));
    localparam logic signed [AW-1:0] SAT_HI = AW'(2 ** (hfd_pkg::SAMPLE_BITS - 1) - 1);
    localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

    hfd_pkg::mac_ctrl_t                       ctrl_a_reg;
    logic signed [hfd_pkg::PROD_W-1:0]        prod_i_reg;
    logic signed [hfd_pkg::PROD_W-1:0]        prod_q_reg;
    logic signed [hfd_pkg::ACC_W-1:0]         acc_i_reg;
    logic signed [hfd_pkg::ACC_W-1:0]         acc_q_reg;
    logic                                     last_b_reg;
    logic                                     done_reg;
    logic [hfd_pkg::SAMPLE_BITS-1:0]          res_i_reg;
    logic [hfd_pkg::SAMPLE_BITS-1:0]          res_q_reg;

    function automatic logic [hfd_pkg::SAMPLE_BITS-1:0] round_sat(
        input logic signed [hfd_pkg::ACC_W-1:0] acc
    );
        logic signed [AW-1:0] v;
        logic signed [AW-1:0] q;
        v = AW'(acc) + RND;
        q = v >>> (hfd_pkg::COEF_BITS - 1);
        if (q > SAT_HI)
        begin
            q = SAT_HI;
        end
        else if (q < SAT_LO)
        begin
            q = SAT_LO;
        end
        return q[hfd_pkg::SAMPLE_BITS-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_a_reg <= '0;
            last_b_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            ctrl_a_reg <= ctrl;
            last_b_reg <= ctrl_a_reg.valid & ctrl_a_reg.last;
            done_reg   <= last_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.valid)
        begin
            if (ctrl.hvalid)
            begin
                prod_i_reg <= $signed(coef) * $signed(hist[hfd_pkg::SAMPLE_BITS-1:0]);
                prod_q_reg <= $signed(coef) *
                              $signed(hist[hfd_pkg::HIST_W-1:hfd_pkg::SAMPLE_BITS]);
            end
            else
            begin
                prod_i_reg <= '0;
                prod_q_reg <= '0;
            end
        end
        if (ctrl_a_reg.valid)
        begin
            if (ctrl_a_reg.first)
            begin
                acc_i_reg <= hfd_pkg::ACC_W'(prod_i_reg);
                acc_q_reg <= hfd_pkg::ACC_W'(prod_q_reg);
            end
            else
            begin
                acc_i_reg <= acc_i_reg + hfd_pkg::ACC_W'(prod_i_reg);
                acc_q_reg <= acc_q_reg + hfd_pkg::ACC_W'(prod_q_reg);
            end
        end
        if (last_b_reg)
        begin
            res_i_reg <= round_sat(acc_i_reg);
            res_q_reg <= round_sat(acc_q_reg);
        end
    end

    assign done  = done_reg;
    assign res_i = res_i_reg;
    assign res_q = res_q_reg;

endmodule

### rtl/core/halfband_fir_decimate_by_two_top.sv
// Flow: the shared MAC walks (len+1)/2 + 1 taps per emitting sample; no further word is accepted
// until its result moves to the output register, which waits while the last output word is held;
// other words leave the input ready.
// Reset: history reads as zero (fill count), next sample emits, length 11, coefs unset.
// Top level: sequencer, history and coefficient RAMs, output register.
// Depends on hfd_pkg, hfd_ram, hfd_mac.
module halfband_fir_decimate_by_two_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // coef_index[5:0], coef_value[23:6], sample_i[39:24], sample_q[55:40]
    input  logic [55:0] s_tdata,
    // req_type[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_i[15:0], out_q[31:16]
    output logic [31:0] m_tdata,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata
);

    localparam int AW = hfd_pkg::ADDR_W;
    localparam int LW = hfd_pkg::LW;
    localparam int CW = hfd_pkg::CNT_W;
    localparam int SB = hfd_pkg::SAMPLE_BITS;
    localparam int CB = hfd_pkg::COEF_BITS;

    hfd_pkg::state_t            state_reg, state_next;
    logic [hfd_pkg::LEN_W-1:0]  flen_reg;
    logic [LW-1:0]              len_reg, len_next;
    logic [LW-1:0]              k_reg, k_next;
    logic [AW-1:0]              wp_reg, wp_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic                       phase_reg, phase_next;
    logic                       out_valid_reg, out_valid_next;
    logic [31:0]                out_data_reg;
    hfd_pkg::mac_ctrl_t         rd_ctrl_reg, rd_ctrl_next;

    logic                       accept;
    logic                       is_coef;
    logic [LW-1:0]              len_raw, len_eff;
    logic [LW-1:0]              n_even, tap, dly;
    logic                       hist_we;
    logic [AW-1:0]              hist_raddr;
    logic [hfd_pkg::HIST_W-1:0] hist_rdata;
    logic [CB-1:0]              coef_rdata;
    logic                       mac_done;
    logic [SB-1:0]              res_i, res_q;
    logic                       load_out;

    assign accept  = s_tvalid & s_tready;
    assign is_coef = (s_tuser[0] == hfd_pkg::REQ_COEF);
    assign hist_we = accept & (s_tuser[0] == hfd_pkg::REQ_SAMPLE);

    always_comb
    begin
        len_raw = LW'(flen_reg);
        if (len_raw < LW'(hfd_pkg::LEN_MIN))
        begin
            len_eff = LW'(hfd_pkg::LEN_MIN);
        end
        else if (len_raw > LW'(hfd_pkg::MAX_TAPS))
        begin
            len_eff = LW'(hfd_pkg::MAX_TAPS);
        end
        else
        begin
            len_eff = len_raw;
        end
    end

    // even taps first, centre tap last
    always_comb
    begin
        n_even = (len_reg + LW'(1)) >> 1;
        if (k_reg < n_even)
        begin
            tap = k_reg << 1;
        end
        else
        begin
            tap = (len_reg - LW'(1)) >> 1;
        end
        dly        = len_reg - LW'(1) - tap;
        hist_raddr = wp_reg - dly[AW-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        k_next         = k_reg;
        wp_next        = wp_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        rd_ctrl_next   = '0;
        load_out       = 1'b0;
        s_tready       = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            hfd_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (hist_we)
                begin
                    wp_next    = wp_reg + AW'(1);
                    phase_next = ~phase_reg;
                    if (cnt_reg != CW'(hfd_pkg::MAX_TAPS))
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                    if (!phase_reg)
                    begin
                        len_next   = len_eff;
                        k_next     = '0;
                        state_next = hfd_pkg::ST_RUN;
                    end
                end
            end
            hfd_pkg::ST_RUN:
            begin
                rd_ctrl_next.valid  = 1'b1;
                rd_ctrl_next.first  = (k_reg == '0);
                rd_ctrl_next.last   = (k_reg == n_even);
                rd_ctrl_next.hvalid = (dly < LW'(cnt_reg));
                k_next              = k_reg + LW'(1);
                if (k_reg == n_even)
                begin
                    state_next = hfd_pkg::ST_DRAIN;
                end
            end
            hfd_pkg::ST_DRAIN:
            begin
                if (mac_done)
                begin
                    state_next = hfd_pkg::ST_HOLD;
                end
            end
            hfd_pkg::ST_HOLD:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = hfd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hfd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hfd_pkg::ST_IDLE;
            flen_reg      <= hfd_pkg::LEN_RESET;
            len_reg       <= '0;
            k_reg         <= '0;
            wp_reg        <= '0;
            cnt_reg       <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            rd_ctrl_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            k_reg         <= k_next;
            wp_reg        <= wp_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            rd_ctrl_reg   <= rd_ctrl_next;
            if (cfg_we)
            begin
                flen_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= {res_q, res_i};
        end
    end

    hfd_ram #(
        .WIDTH (hfd_pkg::HIST_W),
        .DEPTH (hfd_pkg::MAX_TAPS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (wp_reg + AW'(1)),
        .wdata (s_tdata[55:24]),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    hfd_ram #(
        .WIDTH (CB),
        .DEPTH (hfd_pkg::MAX_TAPS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (accept & is_coef),
        .waddr (s_tdata[AW-1:0]),
        .wdata (s_tdata[23:6]),
        .raddr (tap[AW-1:0]),
        .rdata (coef_rdata)
    );

    hfd_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (rd_ctrl_reg),
        .coef  (coef_rdata),
        .hist  (hist_rdata),
        .done  (mac_done),
        .res_i (res_i),
        .res_q (res_q)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### tb/halfband_fir_decimate_by_two_top_tb.sv
// Self-checking testbench for the halfband decimate-by-two FIR: stream driver and monitor,
// an in-bench filter predictor, length changes between phases and random stalls.
// Depends on hfd_pkg and halfband_fir_decimate_by_two_top.
module halfband_fir_decimate_by_two_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 80;
    localparam int PHASES         = 12;
    localparam int PHASE_WORDS    = 150;

    typedef struct {
        logic                                   req;
        logic [hfd_pkg::ADDR_W-1:0]             idx;
        logic signed [hfd_pkg::COEF_BITS-1:0]   cval;
        logic signed [hfd_pkg::SAMPLE_BITS-1:0] si;
        logic signed [hfd_pkg::SAMPLE_BITS-1:0] sq;
    } fir_word_t;

    typedef struct {
        logic signed [hfd_pkg::SAMPLE_BITS-1:0] i;
        logic signed [hfd_pkg::SAMPLE_BITS-1:0] q;
    } iq_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [5:0]  cfg_wdata = '0;

    fir_word_t tx_words[$];
    iq_t       expected_iq[$];

    logic signed [hfd_pkg::SAMPLE_BITS-1:0] hist_i [hfd_pkg::MAX_TAPS];
    logic signed [hfd_pkg::SAMPLE_BITS-1:0] hist_q [hfd_pkg::MAX_TAPS];
    logic signed [hfd_pkg::COEF_BITS-1:0]   coef_tbl [hfd_pkg::MAX_TAPS];
    logic                                   skip_next;
    int                                     len_cfg;

    int      send_idle_pct;
    int      recv_idle_pct;
    int      n_accepted;
    int      held_seq;
    int      quiet_cycles;
    int      mismatches;
    iq_t     want;
    iq_t     got;

    halfband_fir_decimate_by_two_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic signed [hfd_pkg::SAMPLE_BITS-1:0] round_clip(longint acc);
        longint top;
        longint v;
        top = (longint'(1) <<< (hfd_pkg::SAMPLE_BITS - 1)) - 1;
        v = (acc + (longint'(1) <<< (hfd_pkg::COEF_BITS - 2))) >>> (hfd_pkg::COEF_BITS - 1);
        if (v > top)
            v = top;
        else if (v < -top - 1)
            v = -top - 1;
        return v[hfd_pkg::SAMPLE_BITS-1:0];
    endfunction

    function automatic void decimate_step(fir_word_t w);
        int     taps;
        int     ctr;
        longint acc_i;
        longint acc_q;
        iq_t    r;
        if (w.req == hfd_pkg::REQ_COEF)
        begin
            coef_tbl[w.idx] = w.cval;
            return;
        end
        for (int k = hfd_pkg::MAX_TAPS - 1; k > 0; k--)
        begin
            hist_i[k] = hist_i[k-1];
            hist_q[k] = hist_q[k-1];
        end
        hist_i[0] = w.si;
        hist_q[0] = w.sq;
        skip_next = ~skip_next;
        if (!skip_next)
            return;
        taps = (len_cfg < hfd_pkg::LEN_MIN) ? hfd_pkg::LEN_MIN :
               ((len_cfg > hfd_pkg::MAX_TAPS) ? hfd_pkg::MAX_TAPS : len_cfg);
        acc_i = 0;
        acc_q = 0;
        for (int k = 0; k < taps; k += 2)
        begin
            acc_i += longint'(coef_tbl[k]) * longint'(hist_i[taps-1-k]);
            acc_q += longint'(coef_tbl[k]) * longint'(hist_q[taps-1-k]);
        end
        ctr = (taps - 1) / 2;
        acc_i += longint'(coef_tbl[ctr]) * longint'(hist_i[taps-1-ctr]);
        acc_q += longint'(coef_tbl[ctr]) * longint'(hist_q[taps-1-ctr]);
        r.i = round_clip(acc_i);
        r.q = round_clip(acc_q);
        expected_iq.push_back(r);
    endfunction

    function automatic logic signed [hfd_pkg::SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'(int'($urandom_range(0, 16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [hfd_pkg::COEF_BITS-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0:       return 18'sh1ffff;
            1:       return 18'sh20000;
            2, 3:    return 18'($urandom);
            default: return 18'(int'($urandom_range(0, 16383)) - 8192);
        endcase
    endfunction

    function automatic fir_word_t make_word(logic req, logic [hfd_pkg::ADDR_W-1:0] idx,
                                            logic signed [hfd_pkg::COEF_BITS-1:0] cval,
                                            logic signed [hfd_pkg::SAMPLE_BITS-1:0] si,
                                            logic signed [hfd_pkg::SAMPLE_BITS-1:0] sq);
        fir_word_t w;
        w.req  = req;
        w.idx  = idx;
        w.cval = cval;
        w.si   = si;
        w.sq   = sq;
        return w;
    endfunction

    // sample words carry junk in the coefficient fields and vice versa
    function automatic fir_word_t random_word();
        if ($urandom_range(0, 9) == 0)
            return make_word(hfd_pkg::REQ_COEF, 6'($urandom), pick_coef(), pick_sample(),
                             pick_sample());
        return make_word(hfd_pkg::REQ_SAMPLE, 6'($urandom), 18'($urandom), pick_sample(),
                         pick_sample());
    endfunction

    task automatic wait_drained();
        while (tx_words.size() != 0 || expected_iq.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_all_coefs(bit directed);
        logic signed [hfd_pkg::COEF_BITS-1:0] v;
        for (int k = 0; k < hfd_pkg::MAX_TAPS; k++)
        begin
            v = pick_coef();
            if (directed && (k <= 10 && (k % 2 == 0 || k == 5)))
                v = 18'sh1ffff;
            else if (directed && k == hfd_pkg::MAX_TAPS - 1)
                v = 18'sh20000;
            tx_words.push_back(make_word(hfd_pkg::REQ_COEF, 6'(k), v, pick_sample(),
                                         pick_sample()));
        end
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (!(s_tvalid && held_seq == n_accepted))
            begin
                if (tx_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {tx_words[0].sq, tx_words[0].si, tx_words[0].cval,
                                 tx_words[0].idx};
                    s_tuser  <= tx_words[0].req;
                    held_seq <= n_accepted;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                decimate_step(tx_words.pop_front());
                n_accepted++;
            end
            if (m_tvalid && m_tready)
            begin
                got.i = m_tdata[15:0];
                got.q = m_tdata[31:16];
                if (expected_iq.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output word: i=%0d q=%0d", got.i, got.q);
                end
                else
                begin
                    want = expected_iq.pop_front();
                    if (want.i != got.i || want.q != got.q)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected i=%0d q=%0d, got i=%0d q=%0d",
                                     want.i, want.q, got.i, got.q);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        int lengths [PHASES];
        lengths = '{11, 3, 63, 0, 7, 10, 1, 31, 2, 47, 6, 63};
        for (int k = 0; k < hfd_pkg::MAX_TAPS; k++)
        begin
            hist_i[k]   = '0;
            hist_q[k]   = '0;
            coef_tbl[k] = '0;
        end
        skip_next     = 1'b0;
        len_cfg       = int'(hfd_pkg::LEN_RESET);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        n_accepted    = 0;
        held_seq      = -1;
        quiet_cycles  = 0;
        mismatches    = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                wait_drained();
                repeat (SETTLE_CYCLES) @(posedge clk);
                @(negedge clk);
                cfg_we    <= 1'b1;
                cfg_wdata <= 6'(lengths[ph]);
                len_cfg    = lengths[ph];
                @(negedge clk);
                cfg_we    <= 1'b0;
            end
            case (ph / 4)
                0:       begin send_idle_pct = 30; recv_idle_pct = 61; end
                1:       begin send_idle_pct = 61; recv_idle_pct = 30; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase

            if (ph == 0)
            begin
                // taps in use at full scale: full-scale input saturates both rails
                load_all_coefs(1'b1);
                repeat (12)
                    tx_words.push_back(make_word(hfd_pkg::REQ_SAMPLE, 6'h3f, 18'sh20000,
                                                 16'sh7fff, 16'sh8000));
                tx_words.push_back(make_word(hfd_pkg::REQ_COEF, 6'd0, 18'sh20000, 16'sh7fff,
                                             16'sh8000));
                repeat (4)
                    tx_words.push_back(make_word(hfd_pkg::REQ_SAMPLE, 6'd0, 18'sh1ffff,
                                                 16'sh8000, 16'sh7fff));
                repeat (4)
                    tx_words.push_back(make_word(hfd_pkg::REQ_SAMPLE, 6'h2a, 18'h15555,
                                                 16'sd0, 16'sd0));
                tx_words.push_back(make_word(hfd_pkg::REQ_SAMPLE, 6'h15, 18'h2aaaa,
                                             16'sd1, -16'sd1));
                tx_words.push_back(make_word(hfd_pkg::REQ_SAMPLE, 6'h15, 18'h2aaaa,
                                             -16'sd1, 16'sd1));
                wait_drained();
                load_all_coefs(1'b0);
            end

            for (int n = 0; n < PHASE_WORDS / 2; n++)
                tx_words.push_back(random_word());
            wait_drained();
            for (int n = 0; n < PHASE_WORDS / 2; n++)
                tx_words.push_back(random_word());
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
